// ----- src/arl_pkg.sv -----
// Shared types and constants for the atlas rectangle allocator.
// No dependencies.
package arl_pkg;

   localparam int MAX_FREE_SLOTS_DEF = 64;
   localparam int MAX_ATLAS_SIDE_DEF = 4096;
   localparam int ATLAS_RESET_SIDE   = 1024;
   localparam int REQ_W              = 12;
   localparam int OUT_XY_W           = 12;
   localparam int OUT_WH_W           = 13;
   localparam int CSR_W              = 13;
   localparam int MIN_SPLIT_DIM      = 2;

   typedef enum logic [1:0] {
      STAT_PLACED = 2'd0,
      STAT_NOFIT  = 2'd1,
      STAT_FULL   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_SHIFT,
      ST_PUSH_B,
      ST_PUSH_A,
      ST_DONE
   } state_type;

endpackage

// ----- src/arl_if.sv -----
// Valid/ready channels of the allocator: request and response.
// Depends on arl_pkg.
interface arl_req_if;
   logic                        valid;
   logic                        ready;
   logic [arl_pkg::REQ_W-1:0]   req_width;
   logic [arl_pkg::REQ_W-1:0]   req_height;
   modport source (output valid, req_width, req_height, input ready);
   modport sink   (input valid, req_width, req_height, output ready);
endinterface

interface arl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [arl_pkg::OUT_XY_W-1:0]  slot_x;
   logic [arl_pkg::OUT_XY_W-1:0]  slot_y;
   logic [arl_pkg::OUT_WH_W-1:0]  slot_width;
   logic [arl_pkg::OUT_WH_W-1:0]  slot_height;
   modport source (output valid, status, slot_x, slot_y, slot_width, slot_height,
                   input ready);
   modport sink   (input valid, status, slot_x, slot_y, slot_width, slot_height,
                   output ready);
endinterface

// ----- src/arl_slot_mem.sv -----
// Free-slot store: one write port, one read port, registered read data.
// No dependencies.
module arl_slot_mem #(
   parameter int DEPTH = 64,
   parameter int DW    = 50
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DW-1:0]            wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DW-1:0]            rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/arl_ctrl.sv -----
// Sequencer and datapath: first-fit scan, list compaction, child push.
// Depends on arl_pkg, arl_if, drives arl_slot_mem.
module arl_ctrl #(
   parameter int MAX_FREE_SLOTS = arl_pkg::MAX_FREE_SLOTS_DEF,
   parameter int MAX_ATLAS_SIDE = arl_pkg::MAX_ATLAS_SIDE_DEF,
   parameter int SW = 13,
   parameter int CW = 12,
   parameter int AW = 6,
   parameter int DW = 50
) (
   input  logic                     clock,
   input  logic                     reset,
   arl_req_if.sink                  req_bus,
   arl_rsp_if.source                rsp_bus,
   input  logic                     csr_write_enable,
   input  logic [arl_pkg::CSR_W-1:0] csr_write_data,
   output logic                     mem_we,
   output logic [AW-1:0]            mem_waddr,
   output logic [DW-1:0]            mem_wdata,
   output logic [AW-1:0]            mem_raddr,
   input  logic [DW-1:0]            mem_rdata
);

   localparam int CNTW = $clog2(MAX_FREE_SLOTS + 1);
   localparam int RST_SIDE = (arl_pkg::ATLAS_RESET_SIDE > MAX_ATLAS_SIDE) ?
                             MAX_ATLAS_SIDE : arl_pkg::ATLAS_RESET_SIDE;

   arl_pkg::state_type state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in, cnt_m1;
   logic [AW-1:0]   cur_ff, cur_in;
   logic [SW-1:0]   atlas_ff, atlas_in, csr_ext;
   logic [SW-1:0]   pw_ff, pw_in, ph_ff, ph_in;
   logic [DW-1:0]   s_ff, s_in, a_ff, a_in, b_ff, b_in;
   logic            split_ff, split_in;
   logic [1:0]      stat_ff, stat_in;
   logic            rv_ff, rv_in;
   logic [1:0]      rstat_ff, rstat_in;
   logic [arl_pkg::OUT_XY_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [arl_pkg::OUT_WH_W-1:0] rw_ff, rw_in, rh_ff, rh_in;

   logic [CW-1:0] sx, sy;
   logic [SW-1:0] sw, sh, dw, dh, lw, lh;
   logic          fit, accept, load;

   assign sx = s_ff[DW-1 -: CW];
   assign sy = s_ff[DW-1-CW -: CW];
   assign sw = s_ff[2*SW-1 -: SW];
   assign sh = s_ff[SW-1:0];
   assign dw = mem_rdata[2*SW-1 -: SW];
   assign dh = mem_rdata[SW-1:0];
   assign lw = sw - pw_ff;
   assign lh = sh - ph_ff;
   assign fit = (pw_ff <= dw) && (ph_ff <= dh);
   assign cnt_m1 = cnt_ff - 1'b1;
   assign accept = req_bus.valid && req_bus.ready;
   assign load = !rv_ff || rsp_bus.ready;
   assign csr_ext = SW'(csr_write_data);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         arl_pkg::ST_INIT:   state_in = arl_pkg::ST_IDLE;
         arl_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (cnt_ff == '0) ? arl_pkg::ST_DONE : arl_pkg::ST_SEARCH;
            end
         end
         arl_pkg::ST_SEARCH: begin
            if (fit) begin
               state_in = arl_pkg::ST_DECIDE;
            end else if (cur_ff == '0) begin
               state_in = arl_pkg::ST_DONE;
            end
         end
         arl_pkg::ST_DECIDE: begin
            if ((lw >= SW'(arl_pkg::MIN_SPLIT_DIM) || lh >= SW'(arl_pkg::MIN_SPLIT_DIM))
                && cnt_ff == CNTW'(MAX_FREE_SLOTS)) begin
               state_in = arl_pkg::ST_DONE;
            end else if (CNTW'(cur_ff) == cnt_m1) begin
               state_in = (lw >= SW'(arl_pkg::MIN_SPLIT_DIM) ||
                           lh >= SW'(arl_pkg::MIN_SPLIT_DIM)) ?
                          arl_pkg::ST_PUSH_B : arl_pkg::ST_DONE;
            end else begin
               state_in = arl_pkg::ST_SHIFT;
            end
         end
         arl_pkg::ST_SHIFT: begin
            if (CNTW'(cur_ff) + CNTW'(2) == cnt_ff) begin
               state_in = split_ff ? arl_pkg::ST_PUSH_B : arl_pkg::ST_DONE;
            end
         end
         arl_pkg::ST_PUSH_B: state_in = arl_pkg::ST_PUSH_A;
         arl_pkg::ST_PUSH_A: state_in = arl_pkg::ST_DONE;
         arl_pkg::ST_DONE: begin
            if (load) begin
               state_in = arl_pkg::ST_IDLE;
            end
         end
         default:            state_in = arl_pkg::ST_INIT;
      endcase
      if (csr_write_enable) begin
         state_in = arl_pkg::ST_INIT;
      end
   end

   // outputs and datapath
   always_comb begin
      req_bus.ready = (state_ff == arl_pkg::ST_IDLE);
      mem_we    = 1'b0;
      mem_waddr = cur_ff;
      mem_wdata = mem_rdata;
      mem_raddr = cur_ff;
      cnt_in   = cnt_ff;
      cur_in   = cur_ff;
      atlas_in = atlas_ff;
      pw_in    = pw_ff;
      ph_in    = ph_ff;
      s_in     = s_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      split_in = split_ff;
      stat_in  = stat_ff;
      rv_in    = rv_ff && !rsp_bus.ready;
      rstat_in = rstat_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      rw_in    = rw_ff;
      rh_in    = rh_ff;
      case (state_ff)
         arl_pkg::ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = {{(2*CW){1'b0}}, atlas_ff, atlas_ff};
            cnt_in    = CNTW'(1);
         end
         arl_pkg::ST_IDLE: begin
            mem_raddr = cnt_m1[AW-1:0];
            if (accept) begin
               cur_in  = cnt_m1[AW-1:0];
               pw_in   = SW'(req_bus.req_width) + SW'(2);
               ph_in   = SW'(req_bus.req_height) + SW'(2);
               stat_in = arl_pkg::STAT_NOFIT;
            end
         end
         arl_pkg::ST_SEARCH: begin
            mem_raddr = cur_ff - 1'b1;
            if (fit) begin
               s_in = mem_rdata;
            end else if (cur_ff != '0) begin
               cur_in = cur_ff - 1'b1;
            end
         end
         arl_pkg::ST_DECIDE: begin
            mem_raddr = cur_ff + 1'b1;
            split_in  = lw >= SW'(arl_pkg::MIN_SPLIT_DIM) ||
                        lh >= SW'(arl_pkg::MIN_SPLIT_DIM);
            if (lh <= lw) begin
               a_in = {sx, CW'(SW'(sy) + ph_ff), pw_ff, lh};
               b_in = {CW'(SW'(sx) + pw_ff), sy, lw, sh};
            end else begin
               a_in = {CW'(SW'(sx) + pw_ff), sy, lw, ph_ff};
               b_in = {sx, CW'(SW'(sy) + ph_ff), sw, lh};
            end
            if (split_in && cnt_ff == CNTW'(MAX_FREE_SLOTS)) begin
               stat_in = arl_pkg::STAT_FULL;
            end else begin
               stat_in = arl_pkg::STAT_PLACED;
               if (!split_in && CNTW'(cur_ff) == cnt_m1) begin
                  cnt_in = cnt_m1;
               end
            end
         end
         arl_pkg::ST_SHIFT: begin
            mem_we    = 1'b1;
            mem_raddr = cur_ff + 2'd2;
            cur_in    = cur_ff + 1'b1;
            if (CNTW'(cur_ff) + CNTW'(2) == cnt_ff && !split_ff) begin
               cnt_in = cnt_m1;
            end
         end
         arl_pkg::ST_PUSH_B: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_m1[AW-1:0];
            mem_wdata = b_ff;
         end
         arl_pkg::ST_PUSH_A: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[AW-1:0];
            mem_wdata = a_ff;
            cnt_in    = cnt_ff + 1'b1;
         end
         arl_pkg::ST_DONE: begin
            if (load) begin
               rv_in    = 1'b1;
               rstat_in = stat_ff;
               if (stat_ff == arl_pkg::STAT_PLACED) begin
                  rx_in = arl_pkg::OUT_XY_W'(sx);
                  ry_in = arl_pkg::OUT_XY_W'(sy);
                  rw_in = arl_pkg::OUT_WH_W'(pw_ff);
                  rh_in = arl_pkg::OUT_WH_W'(ph_ff);
               end else begin
                  rx_in = '0;
                  ry_in = '0;
                  rw_in = '0;
                  rh_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
      if (csr_write_enable) begin
         if (csr_ext < SW'(2)) begin
            atlas_in = SW'(2);
         end else if (csr_ext > SW'(MAX_ATLAS_SIDE)) begin
            atlas_in = SW'(MAX_ATLAS_SIDE);
         end else begin
            atlas_in = csr_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arl_pkg::ST_INIT;
         cnt_ff   <= '0;
         atlas_ff <= SW'(RST_SIDE);
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         atlas_ff <= atlas_in;
         rv_ff    <= rv_in;
      end
      cur_ff   <= cur_in;
      pw_ff    <= pw_in;
      ph_ff    <= ph_in;
      s_ff     <= s_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      split_ff <= split_in;
      stat_ff  <= stat_in;
      rstat_ff <= rstat_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      rw_ff    <= rw_in;
      rh_ff    <= rh_in;
   end

   assign rsp_bus.valid       = rv_ff;
   assign rsp_bus.status      = rstat_ff;
   assign rsp_bus.slot_x      = rx_ff;
   assign rsp_bus.slot_y      = ry_ff;
   assign rsp_bus.slot_width  = rw_ff;
   assign rsp_bus.slot_height = rh_ff;

endmodule

// ----- src/atlas_rect_allocator_core.sv -----
// Atlas rectangle allocator, top level: slot store plus sequencer.
// Depends on arl_pkg, arl_if, arl_slot_mem, arl_ctrl.
//
// One request is handled at a time. The free list sits in a single-port-write,
// registered-read memory kept with the list front at the highest address. A
// request is accepted in IDLE, then passes through the first-fit scan over the
// slots from the front, a decision state, compaction of the slots that lie ahead
// of the chosen one in the list, a push of the two children when the slot is
// split, and the load of the response register. A request that fits nowhere,
// or one refused on a full list, goes straight from the scan or the decision to
// the response load. The memory port bounds both loops. After reset or an
// atlas_size write the block rebuilds the list in its INIT state before
// accepting a request. A response waiting in the output register stalls only
// the completion of the following request.
module atlas_rect_allocator_core #(
   parameter int MAX_FREE_SLOTS = arl_pkg::MAX_FREE_SLOTS_DEF,
   parameter int MAX_ATLAS_SIDE = arl_pkg::MAX_ATLAS_SIDE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   arl_req_if.sink                   req_bus,
   arl_rsp_if.source                 rsp_bus,
   input  logic                      csr_write_enable,
   input  logic [arl_pkg::CSR_W-1:0] csr_write_data
);

   localparam int SWD = $clog2(MAX_ATLAS_SIDE + 1);
   localparam int SW  = (SWD > arl_pkg::OUT_WH_W) ? SWD : arl_pkg::OUT_WH_W;
   localparam int CW  = SW - 1;
   localparam int AW  = $clog2(MAX_FREE_SLOTS);
   localparam int DW  = 2 * CW + 2 * SW;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [DW-1:0] mem_wdata, mem_rdata;

   arl_slot_mem #(.DEPTH(MAX_FREE_SLOTS), .DW(DW)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   arl_ctrl #(
      .MAX_FREE_SLOTS (MAX_FREE_SLOTS),
      .MAX_ATLAS_SIDE (MAX_ATLAS_SIDE),
      .SW (SW), .CW (CW), .AW (AW), .DW (DW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mem_we           (mem_we),
      .mem_waddr        (mem_waddr),
      .mem_wdata        (mem_wdata),
      .mem_raddr        (mem_raddr),
      .mem_rdata        (mem_rdata)
   );

   a_placed_min: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status == arl_pkg::STAT_PLACED |->
         rsp_bus.slot_width >= 13'd2 && rsp_bus.slot_height >= 13'd2)
      else $error("placed beat smaller than padding");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status != arl_pkg::STAT_PLACED |->
         rsp_bus.slot_x == '0 && rsp_bus.slot_y == '0 &&
         rsp_bus.slot_width == '0 && rsp_bus.slot_height == '0)
      else $error("refused beat carries a slot");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("second request taken while busy");

   a_rebuild_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> !req_bus.ready)
      else $error("request taken during list rebuild");

endmodule

// ----- dv/atlas_rect_allocator_core_tb.sv -----
// Self-checking testbench for atlas_rect_allocator_core: first-fit guillotine
// allocation predicted in-bench and compared beat by beat on the response bus.
// Depends on arl_pkg, arl_if and the allocator RTL.
`timescale 1ns / 1ps

module atlas_rect_allocator_core_tb;

   localparam int SLOTS       = arl_pkg::MAX_FREE_SLOTS_DEF;
   localparam int SIDE_MAX    = arl_pkg::MAX_ATLAS_SIDE_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 160;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      int x;
      int y;
      int w;
      int h;
   } rect_type;

   typedef struct packed {
      arl_pkg::status_type                status;
      logic [arl_pkg::OUT_XY_W-1:0]       x;
      logic [arl_pkg::OUT_XY_W-1:0]       y;
      logic [arl_pkg::OUT_WH_W-1:0]       w;
      logic [arl_pkg::OUT_WH_W-1:0]       h;
   } alloc_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                         csr_write_enable = 1'b0;
   logic [arl_pkg::CSR_W-1:0]    csr_write_data   = '0;

   arl_req_if req_bus ();
   arl_rsp_if rsp_bus ();

   atlas_rect_allocator_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   rect_type  free_list [SLOTS];
   int        free_cnt;
   int        atlas_side;
   alloc_type pending_allocs [$];
   int        errors     = 0;
   int        cycles     = 0;
   int        req_idle   = 0;
   int        rsp_idle   = 0;
   int        hold_req   = 0;
   int        hold_seen  = 0;
   int        hold_left  = 0;

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("atlas_rect_allocator_core_tb: done, errors");
         $finish;
      end
   end

   // receiver: long hold on request, otherwise random idling
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen     <= hold_req;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle);
      end
   end

   always @(posedge clock) begin
      alloc_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_allocs.size() == 0) begin
            $error("unexpected response beat");
            errors++;
         end else begin
            e = pending_allocs.pop_front();
            if (rsp_bus.status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_bus.status);
               errors++;
            end
            if (rsp_bus.slot_x !== e.x) begin
               $error("slot_x: expected %0d, actual %0d", e.x, rsp_bus.slot_x);
               errors++;
            end
            if (rsp_bus.slot_y !== e.y) begin
               $error("slot_y: expected %0d, actual %0d", e.y, rsp_bus.slot_y);
               errors++;
            end
            if (rsp_bus.slot_width !== e.w) begin
               $error("slot_width: expected %0d, actual %0d", e.w, rsp_bus.slot_width);
               errors++;
            end
            if (rsp_bus.slot_height !== e.h) begin
               $error("slot_height: expected %0d, actual %0d", e.h, rsp_bus.slot_height);
               errors++;
            end
         end
      end
   end

   task automatic rebuild_list(input int side);
      atlas_side = (side < 2) ? 2 : (side > SIDE_MAX) ? SIDE_MAX : side;
      foreach (free_list[i]) free_list[i] = '{0, 0, 0, 0};
      free_list[0] = '{0, 0, atlas_side, atlas_side};
      free_cnt = 1;
   endtask

   function automatic alloc_type first_fit(input int rw_req, input int rh_req);
      int pw, ph, hit, rw, rh;
      rect_type s, a, b;
      alloc_type r;
      pw  = (rw_req & 'hFFF) + 2;
      ph  = (rh_req & 'hFFF) + 2;
      hit = -1;
      r   = '{arl_pkg::STAT_NOFIT, '0, '0, '0, '0};
      for (int i = 0; i < free_cnt; i++) begin
         if (hit < 0 && pw <= free_list[i].w && ph <= free_list[i].h) hit = i;
      end
      if (hit < 0) return r;
      s  = free_list[hit];
      rw = s.w - pw;
      rh = s.h - ph;
      if (rw >= arl_pkg::MIN_SPLIT_DIM || rh >= arl_pkg::MIN_SPLIT_DIM) begin
         if (free_cnt + 1 > SLOTS) begin
            r.status = arl_pkg::STAT_FULL;
            return r;
         end
         if (rh <= rw) begin
            a = '{s.x, s.y + ph, pw, rh};
            b = '{s.x + pw, s.y, rw, s.h};
         end else begin
            a = '{s.x + pw, s.y, rw, ph};
            b = '{s.x, s.y + ph, s.w, rh};
         end
         for (int i = hit; i < free_cnt - 1; i++) free_list[i] = free_list[i+1];
         for (int i = free_cnt; i >= 2; i--) free_list[i] = free_list[i-2];
         free_list[0] = a;
         free_list[1] = b;
         free_cnt++;
      end else begin
         for (int i = hit; i < free_cnt - 1; i++) free_list[i] = free_list[i+1];
         free_list[free_cnt-1] = '{0, 0, 0, 0};
         free_cnt--;
      end
      r = '{arl_pkg::STAT_PLACED, s.x[arl_pkg::OUT_XY_W-1:0], s.y[arl_pkg::OUT_XY_W-1:0],
            pw[arl_pkg::OUT_WH_W-1:0], ph[arl_pkg::OUT_WH_W-1:0]};
      return r;
   endfunction

   // valid stays high between back-to-back beats; lowered only for a gap
   task automatic send_req(input int w, input int h);
      alloc_type p;
      if ($urandom_range(99) < req_idle) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_width  <= w[arl_pkg::REQ_W-1:0];
      req_bus.req_height <= h[arl_pkg::REQ_W-1:0];
      do @(posedge clock); while (!req_bus.ready);
      p = first_fit(w, h);
      pending_allocs.insert(pending_allocs.size(), p);
   endtask

   task automatic drain();
      if (req_bus.valid) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      while (pending_allocs.size() != 0) @(posedge clock);
   endtask

   task automatic write_side(input int v);
      drain();
      repeat (SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v[arl_pkg::CSR_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      rebuild_list(int'(v[arl_pkg::CSR_W-1:0]));
   endtask

   task automatic test_reset_side();
      send_req(0, 0);
      send_req(4094, 4094);
      send_req(1021, 1021);
      send_req(1020, 1019);
      send_req(4095, 0);
      drain();
   endtask

   task automatic test_side_extremes();
      write_side(0);
      send_req(0, 0);
      send_req(0, 0);
      write_side(1);
      send_req(1, 0);
      write_side(8191);
      send_req(4094, 4094);
      send_req(0, 0);
      write_side(SIDE_MAX);
      send_req(4094, 0);
      send_req(4093, 4093);
      send_req(1, 2);
      drain();
   endtask

   task automatic test_list_full();
      write_side(SIDE_MAX);
      for (int i = 0; i < 70; i++) send_req(0, 0);
      drain();
   endtask

   task automatic test_stall_backpressure();
      write_side(512);
      hold_req = hold_req + 1;
      for (int i = 0; i < 20; i++) send_req($urandom_range(40), $urandom_range(40));
      drain();
   endtask

   task automatic test_random_mix(input int s_idle, input int r_idle);
      int side;
      req_idle = s_idle;
      rsp_idle = r_idle;
      for (int blk = 0; blk < 4; blk++) begin
         case ($urandom_range(3))
            0: side = 2;
            1: side = SIDE_MAX;
            2: side = $urandom_range(8191);
            default: side = $urandom_range(16, 1024);
         endcase
         write_side(side);
         for (int i = 0; i < 40; i++) begin
            if ($urandom_range(9) == 0)
               send_req($urandom_range(4095), $urandom_range(4095));
            else
               send_req($urandom_range(atlas_side / 4), $urandom_range(atlas_side / 4));
         end
      end
      drain();
   endtask

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.req_width  = '0;
      req_bus.req_height = '0;
      rebuild_list(arl_pkg::ATLAS_RESET_SIDE);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_side();
      test_side_extremes();
      test_list_full();
      test_stall_backpressure();
      test_random_mix(11, 63);
      test_random_mix(63, 11);
      test_random_mix(0, 0);
      drain();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("atlas_rect_allocator_core_tb: done, clean");
      else
         $display("atlas_rect_allocator_core_tb: done, errors");
      $finish;
   end

endmodule

// ----- atlas_rect_allocator_core.f -----
src/arl_pkg.sv
src/arl_if.sv
src/arl_slot_mem.sv
src/arl_ctrl.sv
src/atlas_rect_allocator_core.sv
dv/atlas_rect_allocator_core_tb.sv
